[rtl/core/drs_pkg.sv]
// Package for the drum reversing sequencer.
// Holds phase and command codes, register indexes and shared types; no dependencies.
package drs_pkg;

	localparam int ELAPSED_W = 18;
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

	typedef enum logic [2:0] {
		PH_STOPPED   = 3'd0,
		PH_FWD       = 3'd1,
		PH_PAUSE_REV = 3'd2,
		PH_REV       = 3'd3,
		PH_PAUSE_FWD = 3'd4
	} phase_t;

	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_STOP  = 2'd2;

	localparam logic [1:0] DIR_STOP = 2'd0;
	localparam logic [1:0] DIR_FWD  = 2'd1;
	localparam logic [1:0] DIR_REV  = 2'd2;

	localparam logic [1:0] REG_FWD_SECS   = 2'd0;
	localparam logic [1:0] REG_REV_SECS   = 2'd1;
	localparam logic [1:0] REG_PAUSE_SECS = 2'd2;
	localparam logic [1:0] REG_MIN_PAUSE  = 2'd3;

	localparam logic [7:0]  RST_FWD_SECS   = 8'd45;
	localparam logic [7:0]  RST_REV_SECS   = 8'd45;
	localparam logic [7:0]  RST_PAUSE_SECS = 8'd5;
	localparam logic [15:0] RST_MIN_PAUSE  = 16'd1000;

	typedef struct packed {
		logic [ELAPSED_W-1:0] fwd_ticks;
		logic [ELAPSED_W-1:0] rev_ticks;
		logic [ELAPSED_W-1:0] pause_ticks;
	} dur_t;

endpackage

[rtl/core/drs_cfg_regs.sv]
// APB register file for the drum reversing sequencer.
// Holds the phase time registers and the phase durations in ticks; uses drs_pkg.
module drs_cfg_regs import drs_pkg::*; #(
	parameter int TICKS_PER_SECOND = 1000
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output dur_t        dur
);

	logic [7:0]  fwd_secs_q;
	logic [7:0]  rev_secs_q;
	logic [7:0]  pause_secs_q;
	logic [15:0] min_pause_q;
	dur_t        dur_q;
	logic        wr_en;
	logic [1:0]  reg_idx;
	logic [ELAPSED_W-1:0] pause_scaled;
	localparam logic [ELAPSED_W-1:0] TPS = ELAPSED_W'(TICKS_PER_SECOND);

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_secs_q   <= RST_FWD_SECS;
			rev_secs_q   <= RST_REV_SECS;
			pause_secs_q <= RST_PAUSE_SECS;
			min_pause_q  <= RST_MIN_PAUSE;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_FWD_SECS:   fwd_secs_q   <= pwdata[7:0];
				REG_REV_SECS:   rev_secs_q   <= pwdata[7:0];
				REG_PAUSE_SECS: pause_secs_q <= pwdata[7:0];
				REG_MIN_PAUSE:  min_pause_q  <= pwdata[15:0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_FWD_SECS:   prdata = 32'(fwd_secs_q);
			REG_REV_SECS:   prdata = 32'(rev_secs_q);
			REG_PAUSE_SECS: prdata = 32'(pause_secs_q);
			REG_MIN_PAUSE:  prdata = 32'(min_pause_q);
			default:        prdata = '0;
		endcase
	end

	assign pause_scaled = ELAPSED_W'(pause_secs_q) * TPS;

	// durations are registered and follow the registers in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dur_q.fwd_ticks   <= ELAPSED_W'(RST_FWD_SECS) * TPS;
			dur_q.rev_ticks   <= ELAPSED_W'(RST_REV_SECS) * TPS;
			dur_q.pause_ticks <= (ELAPSED_W'(RST_PAUSE_SECS) * TPS < ELAPSED_W'(RST_MIN_PAUSE))
				? ELAPSED_W'(RST_MIN_PAUSE) : ELAPSED_W'(RST_PAUSE_SECS) * TPS;
		end else begin
			dur_q.fwd_ticks   <= ELAPSED_W'(fwd_secs_q) * TPS;
			dur_q.rev_ticks   <= ELAPSED_W'(rev_secs_q) * TPS;
			dur_q.pause_ticks <= (pause_scaled < ELAPSED_W'(min_pause_q))
				? ELAPSED_W'(min_pause_q) : pause_scaled;
		end
	end

	assign dur = dur_q;

endmodule

[rtl/core/drum_reversing_sequencer.sv]
// Drum reversing sequencer top level.
// Uses drs_pkg and drs_cfg_regs; runs the forward / pause / reverse / pause cycle.
//
// Usage:
//   Input stream (s_axis_*): one beat per millisecond tick or command.
//     tuser carries the kind (tick, start, stop), tdata bit 0 the door level.
//   Output stream (m_axis_*): exactly one status beat per input beat, in order.
//   APB port: four registers at 0x0, 0x4, 0x8, 0xC (forward, reverse and pause
//     seconds, minimum pause in ms). Write only while the stream is idle.
//   Order: an accepted beat is loaded into the input register, then into the
//     output register, from which it can be taken on m_axis.
//   Throughput: one beat per cycle while the receiver does not stall; the input
//     register and the output register each take a new beat whenever the stage after them advances.
//   Phase durations are taken from registers computed from the APB registers,
//     which follow a write in the next cycle.
//   Reset: phase stopped, not running, timer cleared, registers at their
//     defaults, both pipeline stages empty.
//   Receiver stall: the output beat holds; the input register fills behind it
//     and s_axis_tready drops until the output beat is taken.
module drum_reversing_sequencer import drs_pkg::*; #(
	parameter int TICKS_PER_SECOND = 1000
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [0] door_closed, [7:1] zero
	input  logic [1:0]  s_axis_tuser,   // [1:0] kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [1:0] direction, [2] running, [5:3] phase, [7:6] zero
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	dur_t dur;

	logic       valid_s1;
	logic [1:0] kind_s1;
	logic       door_s1;
	logic       adv_s1;

	phase_t               phase_q, phase_d;
	logic                 active_q, active_d;
	logic [ELAPSED_W-1:0] elapsed_q, elapsed_d, elapsed_inc;
	logic [1:0]           dir_d;

	logic       out_valid_q;
	logic [7:0] out_data_q;

	drs_cfg_regs #(
		.TICKS_PER_SECOND(TICKS_PER_SECOND)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.dur     (dur)
	);

	assign adv_s1        = valid_s1 & (~out_valid_q | m_axis_tready);
	assign s_axis_tready = ~valid_s1 | adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			kind_s1 <= s_axis_tuser;
			door_s1 <= s_axis_tdata[0];
		end
	end

	assign elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 1'b1;

	always_comb begin
		phase_d   = phase_q;
		active_d  = active_q;
		elapsed_d = elapsed_q;
		unique case (kind_s1)
			KIND_TICK: begin
				elapsed_d = elapsed_inc;
				if (!door_s1) begin
					if (active_q) begin
						active_d  = 1'b0;
						phase_d   = PH_STOPPED;
						elapsed_d = '0;
					end
				end else if (!active_q) begin
					if (phase_q != PH_STOPPED) begin
						phase_d   = PH_STOPPED;
						elapsed_d = '0;
					end
				end else begin
					unique case (phase_q)
						PH_STOPPED: begin
							phase_d   = PH_FWD;
							elapsed_d = '0;
						end
						PH_FWD: begin
							if (elapsed_inc >= dur.fwd_ticks) begin
								phase_d   = PH_PAUSE_REV;
								elapsed_d = '0;
							end
						end
						PH_PAUSE_REV: begin
							if (elapsed_inc >= dur.pause_ticks) begin
								phase_d   = PH_REV;
								elapsed_d = '0;
							end
						end
						PH_REV: begin
							if (elapsed_inc >= dur.rev_ticks) begin
								phase_d   = PH_PAUSE_FWD;
								elapsed_d = '0;
							end
						end
						PH_PAUSE_FWD: begin
							if (elapsed_inc >= dur.pause_ticks) begin
								phase_d   = PH_FWD;
								elapsed_d = '0;
							end
						end
						default: begin
							phase_d   = PH_STOPPED;
							elapsed_d = '0;
						end
					endcase
				end
			end
			KIND_START: begin
				if (!door_s1) begin
					active_d  = 1'b0;
					phase_d   = PH_STOPPED;
					elapsed_d = '0;
				end else if (!active_q) begin
					active_d  = 1'b1;
					phase_d   = PH_FWD;
					elapsed_d = '0;
				end
			end
			KIND_STOP: begin
				active_d  = 1'b0;
				phase_d   = PH_STOPPED;
				elapsed_d = '0;
			end
			default: ;
		endcase

		dir_d = DIR_STOP;
		if (active_d && phase_d == PH_FWD) begin
			dir_d = DIR_FWD;
		end else if (active_d && phase_d == PH_REV) begin
			dir_d = DIR_REV;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_STOPPED;
			active_q  <= 1'b0;
			elapsed_q <= '0;
		end else if (adv_s1) begin
			phase_q   <= phase_d;
			active_q  <= active_d;
			elapsed_q <= elapsed_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_data_q <= {2'b00, phase_d, active_d, dir_d};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

[rtl/core/drs_checker.sv]
// Port-level checker for the drum reversing sequencer.
// Watches the status stream; bound to drum_reversing_sequencer, uses drs_pkg.
module drs_checker import drs_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata
);

	// hold a stalled beat
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("status beat changed while stalled");

	a_stopped_dir: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[1:0] == DIR_STOP)
		else $error("drive active while not running");

	a_fwd_phase: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1:0] == DIR_FWD |-> m_axis_tdata[5:3] == PH_FWD)
		else $error("forward drive outside forward phase");

	a_rev_phase: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1:0] == DIR_REV |-> m_axis_tdata[5:3] == PH_REV)
		else $error("reverse drive outside reverse phase");

endmodule

bind drum_reversing_sequencer drs_checker u_drs_checker (.*);
